FILE: src/tpe_pkg.sv
package tpe_pkg;

  // Per-item status that travels beside the arithmetic after the determinants
  typedef struct packed {
    logic valid;
    logic degen;
    logic in_tri;
    logic dneg;
  } flag_t;

endpackage

FILE: src/tpe_if.sv
interface tpe_in_if #(
  parameter int W = 40
);
  logic valid;
  logic ready;
  logic signed [W-1:0] vertex_a_x;
  logic signed [W-1:0] vertex_a_y;
  logic signed [W-1:0] vertex_a_z;
  logic signed [W-1:0] vertex_b_x;
  logic signed [W-1:0] vertex_b_y;
  logic signed [W-1:0] vertex_b_z;
  logic signed [W-1:0] vertex_c_x;
  logic signed [W-1:0] vertex_c_y;
  logic signed [W-1:0] vertex_c_z;
  logic signed [W-1:0] query_x;
  logic signed [W-1:0] query_y;

  modport source (
    output valid, vertex_a_x, vertex_a_y, vertex_a_z, vertex_b_x, vertex_b_y,
           vertex_b_z, vertex_c_x, vertex_c_y, vertex_c_z, query_x, query_y,
    input  ready
  );
  modport sink (
    input  valid, vertex_a_x, vertex_a_y, vertex_a_z, vertex_b_x, vertex_b_y,
           vertex_b_z, vertex_c_x, vertex_c_y, vertex_c_z, query_x, query_y,
    output ready
  );
endinterface

interface tpe_out_if #(
  parameter int W = 40
);
  logic valid;
  logic ready;
  logic inside_flag;
  logic degenerate_flag;
  logic signed [W-1:0] elevation;

  modport source (
    output valid, inside_flag, degenerate_flag, elevation,
    input  ready
  );
  modport sink (
    input  valid, inside_flag, degenerate_flag, elevation,
    output ready
  );
endinterface

FILE: src/tpe_geom.sv
module tpe_geom #(
  parameter int W = 40
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic signed [W-1:0]     ax_i,
  input  logic signed [W-1:0]     ay_i,
  input  logic signed [W-1:0]     az_i,
  input  logic signed [W-1:0]     bx_i,
  input  logic signed [W-1:0]     by_i,
  input  logic signed [W-1:0]     bz_i,
  input  logic signed [W-1:0]     cx_i,
  input  logic signed [W-1:0]     cy_i,
  input  logic signed [W-1:0]     cz_i,
  input  logic signed [W-1:0]     qx_i,
  input  logic signed [W-1:0]     qy_i,
  output logic                    valid_o,
  output logic signed [2*W+2:0]   d_o,
  output logic signed [2*W+2:0]   d0_o,
  output logic signed [2*W+2:0]   d1_o,
  output logic signed [2*W+2:0]   d2_o,
  output logic signed [W-1:0]     az_o,
  output logic signed [W-1:0]     bz_o,
  output logic signed [W-1:0]     cz_o
);
  localparam int DW   = W + 1;
  localparam int PW   = 2 * W + 2;
  localparam int DETW = 2 * W + 3;
  localparam int HL   = DW / 2;
  localparam int HH   = DW - HL;
  localparam int PHW  = DW + HH;
  localparam int PLW  = DW + HL + 1;

  logic [3:0] vld_q;
  logic signed [DW-1:0] bax_q, bay_q, cax_q, cay_q, qax_q, qay_q;
  logic signed [DW-1:0] bqx_q, bqy_q, cqx_q, cqy_q;
  logic signed [W-1:0]  z_q [4][3];
  logic signed [DW-1:0] ma [8];
  logic signed [DW-1:0] mb [8];
  logic signed [PHW-1:0] pp_hi_q [8];
  logic signed [PLW-1:0] pp_lo_q [8];
  logic signed [PW-1:0]  prod_q [8];
  logic signed [DETW-1:0] d_q, d0_q, d1_q, d2_q;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  // stage 1: edge differences
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      bax_q <= DW'(bx_i) - DW'(ax_i);
      bay_q <= DW'(by_i) - DW'(ay_i);
      cax_q <= DW'(cx_i) - DW'(ax_i);
      cay_q <= DW'(cy_i) - DW'(ay_i);
      qax_q <= DW'(qx_i) - DW'(ax_i);
      qay_q <= DW'(qy_i) - DW'(ay_i);
      bqx_q <= DW'(bx_i) - DW'(qx_i);
      bqy_q <= DW'(by_i) - DW'(qy_i);
      cqx_q <= DW'(cx_i) - DW'(qx_i);
      cqy_q <= DW'(cy_i) - DW'(qy_i);
      z_q[0][0] <= az_i;
      z_q[0][1] <= bz_i;
      z_q[0][2] <= cz_i;
      for (int s = 1; s < 4; s++) begin
        z_q[s] <= z_q[s-1];
      end
    end
  end

  // operand pairs of the eight cross products
  always_comb begin
    ma[0] = bax_q; mb[0] = cay_q;
    ma[1] = cax_q; mb[1] = bay_q;
    ma[2] = bqx_q; mb[2] = cqy_q;
    ma[3] = cqx_q; mb[3] = bqy_q;
    ma[4] = qax_q; mb[4] = cay_q;
    ma[5] = cax_q; mb[5] = qay_q;
    ma[6] = bax_q; mb[6] = qay_q;
    ma[7] = qax_q; mb[7] = bay_q;
  end

  // stage 2: half-width partial products; stage 3: recombine
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 8; k++) begin
        pp_hi_q[k] <= ma[k] * $signed(mb[k][DW-1:HL]);
        pp_lo_q[k] <= ma[k] * $signed({1'b0, mb[k][HL-1:0]});
        prod_q[k]  <= (PW'(pp_hi_q[k]) <<< HL) + PW'(pp_lo_q[k]);
      end
    end
  end

  // stage 4: doubled signed areas
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q  <= DETW'(prod_q[0]) - DETW'(prod_q[1]);
      d0_q <= DETW'(prod_q[2]) - DETW'(prod_q[3]);
      d1_q <= DETW'(prod_q[4]) - DETW'(prod_q[5]);
      d2_q <= DETW'(prod_q[6]) - DETW'(prod_q[7]);
    end
  end

  assign valid_o = vld_q[3];
  assign d_o     = d_q;
  assign d0_o    = d0_q;
  assign d1_o    = d1_q;
  assign d2_o    = d2_q;
  assign az_o    = z_q[3][0];
  assign bz_o    = z_q[3][1];
  assign cz_o    = z_q[3][2];
endmodule

FILE: src/tpe_interp.sv
module tpe_interp #(
  parameter int W = 40
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic signed [2*W+2:0]   d_i,
  input  logic signed [2*W+2:0]   d0_i,
  input  logic signed [2*W+2:0]   d1_i,
  input  logic signed [2*W+2:0]   d2_i,
  input  logic signed [W-1:0]     az_i,
  input  logic signed [W-1:0]     bz_i,
  input  logic signed [W-1:0]     cz_i,
  output tpe_pkg::flag_t          flag_o,
  output logic signed [2*W+2:0]   d_o,
  output logic signed [3*W+4:0]   num_o
);
  localparam int DETW = 2 * W + 3;
  localparam int ZL   = W / 2;
  localparam int ZH   = W - ZL;
  localparam int ZOW  = ZH + 1;
  // area split into three chunks, the top one signed
  localparam int DC   = (DETW + 2) / 3;
  localparam int DOW  = DC + 1;
  localparam int PPW  = DOW + ZOW;
  localparam int ZPW  = DETW + W;
  localparam int NUMW = 3 * W + 5;

  logic signed [DETW-1:0] det [3];
  logic signed [W-1:0]    zz  [3];
  logic [2:0]             ok;
  tpe_pkg::flag_t         flag_q [3];
  logic [2:0]             vld_q;
  logic signed [DETW-1:0] d_q [3];
  logic signed [DOW-1:0]  dop [3][3];
  logic signed [ZOW-1:0]  zop [3][2];
  logic signed [PPW-1:0]  pz_pp_q [3][6];
  logic signed [ZPW-1:0]  pz_sum [3];
  logic signed [ZPW-1:0]  pz_q [3];
  logic signed [NUMW-1:0] num_q;

  always_comb begin
    det[0] = d0_i; det[1] = d1_i; det[2] = d2_i;
    zz[0]  = az_i; zz[1]  = bz_i; zz[2]  = cz_i;
    // a weight is non-negative when its area is zero or shares the sign of D
    for (int i = 0; i < 3; i++) begin
      ok[i] = (det[i] == '0) || (det[i][DETW-1] == d_i[DETW-1]);
    end
  end

  // multiplier operands: area chunks and elevation halves
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dop[i][0] = DOW'($signed({1'b0, det[i][DC-1:0]}));
      dop[i][1] = DOW'($signed({1'b0, det[i][2*DC-1:DC]}));
      dop[i][2] = DOW'($signed(det[i][DETW-1:2*DC]));
      zop[i][0] = ZOW'($signed({1'b0, zz[i][ZL-1:0]}));
      zop[i][1] = ZOW'($signed(zz[i][W-1:ZL]));
    end
  end

  // weighted sum of the partial products
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pz_sum[i] = '0;
      for (int c = 0; c < 3; c++) begin
        for (int h = 0; h < 2; h++) begin
          pz_sum[i] = pz_sum[i] + (ZPW'(pz_pp_q[i][2*c+h]) <<< (c * DC + h * ZL));
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  // stage 5: flags and partial products; stage 6: recombine; stage 7: sum
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      flag_q[0].valid  <= 1'b0;
      flag_q[0].degen  <= (d_i == '0);
      flag_q[0].dneg   <= d_i[DETW-1];
      flag_q[0].in_tri <= (&ok) && (d_i != '0);
      flag_q[1] <= flag_q[0];
      flag_q[2] <= flag_q[1];
      d_q[0] <= d_i;
      d_q[1] <= d_q[0];
      d_q[2] <= d_q[1];
      for (int i = 0; i < 3; i++) begin
        for (int c = 0; c < 3; c++) begin
          for (int h = 0; h < 2; h++) begin
            pz_pp_q[i][2*c+h] <= dop[i][c] * zop[i][h];
          end
        end
        pz_q[i] <= pz_sum[i];
      end
      num_q <= NUMW'(pz_q[0]) + NUMW'(pz_q[1]) + NUMW'(pz_q[2]);
    end
  end

  always_comb begin
    flag_o       = flag_q[2];
    flag_o.valid = vld_q[2];
  end
  assign d_o   = d_q[2];
  assign num_o = num_q;
endmodule

FILE: src/tpe_div.sv
module tpe_div #(
  parameter int W = 40
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  tpe_pkg::flag_t          flag_i,
  input  logic signed [2*W+2:0]   d_i,
  input  logic signed [3*W+4:0]   num_i,
  output logic                    valid_o,
  output logic                    inside_o,
  output logic                    degen_o,
  output logic signed [W-1:0]     elev_o
);
  localparam int DETW = 2 * W + 3;
  localparam int NUMW = 3 * W + 5;
  localparam int NW   = NUMW + 2;
  localparam int QB   = W + 1;

  logic [NUMW-1:0] absn;
  logic [DETW-1:0] absd;

  logic [NW-1:0]   rem_q  [QB+1];
  logic [NW-1:0]   dv_q   [QB+1];
  logic [QB-1:0]   quot_q [QB+1];
  tpe_pkg::flag_t  flag_q [QB+1];
  logic            rneg_q [QB+1];
  logic            big_q  [QB+1];
  logic            vld_q  [QB+1];

  logic            out_vld_q, inside_q, degen_q;
  logic signed [W-1:0] elev_q;
  logic [QB-1:0]   half, mag;

  assign absn = num_i[NUMW-1] ? NUMW'(-num_i) : NUMW'(num_i);
  assign absd = d_i[DETW-1] ? DETW'(-d_i) : DETW'(d_i);

  // stage 8: rounded operands (2|N| + |D|) / (2|D|)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= flag_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= (NW'(absn) << 1) + NW'(absd);
      dv_q[0]   <= NW'(absd) << 1;
      quot_q[0] <= '0;
      flag_q[0] <= flag_i;
      rneg_q[0] <= num_i[NUMW-1] ^ d_i[DETW-1];
      big_q[0]  <= 1'b0;
    end
  end

  // one quotient bit per stage, most significant first
  for (genvar k = 0; k < QB; k++) begin : g_step
    localparam int SH = QB - 1 - k;
    logic [NW-1:0] sh;
    logic          ge;
    assign sh = dv_q[k] << SH;
    assign ge = rem_q[k] >= sh;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1]  <= ge ? rem_q[k] - sh : rem_q[k];
        dv_q[k+1]   <= dv_q[k];
        quot_q[k+1] <= quot_q[k] | (QB'(ge) << SH);
        flag_q[k+1] <= flag_q[k];
        rneg_q[k+1] <= rneg_q[k];
        if (k == 0) begin
          // quotient too wide for the stages: saturate at the end
          big_q[k+1] <= rem_q[k] >= (dv_q[k] << QB);
        end else begin
          big_q[k+1] <= big_q[k];
        end
      end
    end
  end

  // saturation and sign
  assign half = QB'(1) << (W - 1);
  always_comb begin
    if (!rneg_q[QB]) begin
      mag = (big_q[QB] || quot_q[QB] > half - QB'(1)) ? half - QB'(1) : quot_q[QB];
    end else begin
      mag = (big_q[QB] || quot_q[QB] > half) ? half : quot_q[QB];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en_i) begin
      out_vld_q <= vld_q[QB];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      degen_q  <= flag_q[QB].degen;
      inside_q <= flag_q[QB].in_tri;
      if (flag_q[QB].degen) begin
        elev_q <= '0;
      end else if (rneg_q[QB]) begin
        elev_q <= W'(-mag);
      end else begin
        elev_q <= W'(mag);
      end
    end
  end

  assign valid_o  = out_vld_q;
  assign inside_o = inside_q;
  assign degen_o  = degen_q;
  assign elev_o   = elev_q;

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && degen_q |-> elev_q == '0 && !inside_q)
    else $error("degenerate result carries elevation or inside");
  a_inside_ndeg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[QB] && flag_q[QB].in_tri |-> !flag_q[QB].degen)
    else $error("inside flag on degenerate triangle");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> $stable(out_vld_q) && $stable(vld_q[QB]) && $stable(quot_q[QB]))
    else $error("pipeline moved while stalled");
  a_sat_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[QB] && !rneg_q[QB] |-> mag < half)
    else $error("positive elevation out of range");
endmodule

FILE: src/triangle_point_elevation_top.sv
// Triangle point elevation.
// in_i (sink) carries one triangle A, B, C with x, y, z per vertex and a
// query point x, y; a transfer happens when valid and ready are both high.
// out_o (source) carries inside_flag, degenerate_flag and the plane
// elevation at the query point, rounded half away from zero, saturated.
// Stages: 4 of differences, cross products and areas, 3 of interpolation
// products and sum, 1 of rounding setup, COORD_BITS + 1 restoring divider
// stages (one quotient bit each) and the output register. Throughput is
// one item per cycle while no result waits on out_o; every stage is registered.
// While out_o holds a result that is not taken, the whole pipeline holds
// and in_i.ready is low; nothing is dropped or repeated.
// Reset clears all valid bits; no result is pending after reset, and the
// block is ready for input once reset is released.
module triangle_point_elevation_top #(
  parameter int COORD_BITS = 40
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  tpe_in_if.sink         in_i,
  tpe_out_if.source      out_o
);
  localparam int W = COORD_BITS;

  logic en;
  logic g_valid;
  logic signed [2*W+2:0] g_d, g_d0, g_d1, g_d2, i_d;
  logic signed [W-1:0]   g_az, g_bz, g_cz;
  logic signed [3*W+4:0] i_num;
  tpe_pkg::flag_t        i_flag;

  // global advance: hold everything while a result waits
  assign en = !out_o.valid || out_o.ready;
  assign in_i.ready = en;

  tpe_geom #(.W(W)) u_geom (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_i.valid),
    .ax_i(in_i.vertex_a_x), .ay_i(in_i.vertex_a_y), .az_i(in_i.vertex_a_z),
    .bx_i(in_i.vertex_b_x), .by_i(in_i.vertex_b_y), .bz_i(in_i.vertex_b_z),
    .cx_i(in_i.vertex_c_x), .cy_i(in_i.vertex_c_y), .cz_i(in_i.vertex_c_z),
    .qx_i(in_i.query_x), .qy_i(in_i.query_y),
    .valid_o(g_valid), .d_o(g_d), .d0_o(g_d0), .d1_o(g_d1), .d2_o(g_d2),
    .az_o(g_az), .bz_o(g_bz), .cz_o(g_cz)
  );

  tpe_interp #(.W(W)) u_interp (
    .clk_i, .rst_ni, .en_i(en), .valid_i(g_valid),
    .d_i(g_d), .d0_i(g_d0), .d1_i(g_d1), .d2_i(g_d2),
    .az_i(g_az), .bz_i(g_bz), .cz_i(g_cz),
    .flag_o(i_flag), .d_o(i_d), .num_o(i_num)
  );

  tpe_div #(.W(W)) u_div (
    .clk_i, .rst_ni, .en_i(en), .flag_i(i_flag), .d_i(i_d), .num_i(i_num),
    .valid_o(out_o.valid), .inside_o(out_o.inside_flag),
    .degen_o(out_o.degenerate_flag), .elev_o(out_o.elevation)
  );
endmodule
